// File: rtl/core/mksm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_pkg
// Types, constants and the per-keyword match step of the two-keyword
// stream matcher.
// ----------------------------------------------------------------------------
package mksm_pkg;

   localparam int unsigned MaxKeywordChars = 8;
   localparam int unsigned CharWidth       = 8;
   localparam int unsigned TextWidth       = 64;
   localparam int unsigned LengthWidth     = 4;
   localparam int unsigned PosWidth        = 3;
   localparam int unsigned CsrIndexWidth   = 2;

   typedef logic [CharWidth-1:0]     char_type;
   typedef logic [TextWidth-1:0]     text_type;
   typedef logic [LengthWidth-1:0]   length_type;
   typedef logic [PosWidth-1:0]      pos_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   // register indexes of the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEYWORD_TEXT_0   = 2'd0,
      CSR_KEYWORD_LENGTH_0 = 2'd1,
      CSR_KEYWORD_TEXT_1   = 2'd2,
      CSR_KEYWORD_LENGTH_1 = 2'd3
   } csr_reg_type;

   localparam text_type   KeywordText0Reset   = 64'h0000_0078_756E_694C;
   localparam length_type KeywordLength0Reset = 4'd5;
   localparam text_type   KeywordText1Reset   = 64'h0000_0000_6863_7241;
   localparam length_type KeywordLength1Reset = 4'd3;

   localparam length_type MaxLength = length_type'(MaxKeywordChars);

   typedef struct packed {
      logic hit_first;
      logic hit_second;
      logic seen_first;
      logic seen_second;
   } result_type;

   typedef struct packed {
      pos_type next_pos;
      logic    hit;
   } step_type;

   function automatic step_type match_step(text_type text, length_type len, pos_type pos,
                                           char_type rx_byte);
      length_type eff_len;
      length_type next;
      step_type   res;
      if (len == '0) begin
         eff_len = length_type'(1);
      end else if (len > MaxLength) begin
         eff_len = MaxLength;
      end else begin
         eff_len = len;
      end
      if (text[{pos, 3'b000} +: CharWidth] == rx_byte) begin
         next = {1'b0, pos} + length_type'(1);
      end else if (text[CharWidth-1:0] == rx_byte) begin
         next = length_type'(1);
      end else begin
         next = '0;
      end
      // completed keyword, also a stale position past a shortened length
      if (next >= eff_len) begin
         res.hit      = 1'b1;
         res.next_pos = '0;
      end else begin
         res.hit      = 1'b0;
         res.next_pos = next[PosWidth-1:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/core/mksm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_req_if / mksm_rsp_if
// Valid/ready channels carrying received bytes in and match results out.
// ----------------------------------------------------------------------------
interface mksm_req_if;
   logic               valid;
   logic               ready;
   mksm_pkg::char_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mksm_rsp_if;
   logic valid;
   logic ready;
   logic hit_first;
   logic hit_second;
   logic seen_first;
   logic seen_second;

   modport source (output valid, output hit_first, output hit_second,
                   output seen_first, output seen_second, input ready);
   modport sink   (input valid, input hit_first, input hit_second,
                   input seen_first, input seen_second, output ready);
endinterface

// File: rtl/core/multi_keyword_stream_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_keyword_stream_matcher_unit
// Watches a byte stream for two configurable keywords, one result per byte.
// ----------------------------------------------------------------------------
// each result is registered in the output register after its byte transfer, or
// sits in the skid entry while the output stalls and the output register is full
// throughput: 1 byte per cycle while the skid entry is empty, set by the single match update per keyword
// a two-entry output buffer keeps input flowing while a result waits
// reset (synchronous): match positions and seen flags cleared, keywords back
// to their default text and length, output buffer empty, input not ready
module multi_keyword_stream_matcher_unit (
   input  logic                         clock,
   input  logic                         reset,
   mksm_req_if.sink                     req_port,
   mksm_rsp_if.source                   rsp_port,
   input  logic                         csr_write_enable,
   input  mksm_pkg::csr_index_type      csr_index,
   input  mksm_pkg::text_type           csr_write_data
);

   mksm_pkg::text_type   text0_ff, text0_in, text1_ff, text1_in;
   mksm_pkg::length_type len0_ff, len0_in, len1_ff, len1_in;
   mksm_pkg::pos_type    pos0_ff, pos0_in, pos1_ff, pos1_in;
   logic                 seen0_ff, seen0_in, seen1_ff, seen1_in;

   mksm_pkg::result_type out_ff, out_in, skid_ff, skid_in, new_result;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   mksm_pkg::step_type   step0, step1;
   logic                 push, pop;

   assign req_port.ready = !reset && !skid_valid_ff;
   assign push = req_port.valid && !reset && !skid_valid_ff;
   assign pop  = out_valid_ff && rsp_port.ready;

   assign step0 = mksm_pkg::match_step(text0_ff, len0_ff, pos0_ff, req_port.rx_byte);
   assign step1 = mksm_pkg::match_step(text1_ff, len1_ff, pos1_ff, req_port.rx_byte);

   always_comb begin
      new_result.hit_first   = step0.hit;
      new_result.hit_second  = step1.hit;
      new_result.seen_first  = seen0_ff | step0.hit;
      new_result.seen_second = seen1_ff | step1.hit;
   end

   // configuration writes
   always_comb begin
      text0_in = text0_ff;
      len0_in  = len0_ff;
      text1_in = text1_ff;
      len1_in  = len1_ff;
      if (csr_write_enable) begin
         unique case (mksm_pkg::csr_reg_type'(csr_index))
            mksm_pkg::CSR_KEYWORD_TEXT_0:   text0_in = csr_write_data;
            mksm_pkg::CSR_KEYWORD_LENGTH_0: len0_in  = csr_write_data[mksm_pkg::LengthWidth-1:0];
            mksm_pkg::CSR_KEYWORD_TEXT_1:   text1_in = csr_write_data;
            mksm_pkg::CSR_KEYWORD_LENGTH_1: len1_in  = csr_write_data[mksm_pkg::LengthWidth-1:0];
            default: ;
         endcase
      end
   end

   // match state advances on each byte transfer
   always_comb begin
      pos0_in  = pos0_ff;
      pos1_in  = pos1_ff;
      seen0_in = seen0_ff;
      seen1_in = seen1_ff;
      if (push) begin
         pos0_in  = step0.next_pos;
         pos1_in  = step1.next_pos;
         seen0_in = new_result.seen_first;
         seen1_in = new_result.seen_second;
      end
   end

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text0_ff      <= mksm_pkg::KeywordText0Reset;
         len0_ff       <= mksm_pkg::KeywordLength0Reset;
         text1_ff      <= mksm_pkg::KeywordText1Reset;
         len1_ff       <= mksm_pkg::KeywordLength1Reset;
         pos0_ff       <= '0;
         pos1_ff       <= '0;
         seen0_ff      <= 1'b0;
         seen1_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         text0_ff      <= text0_in;
         len0_ff       <= len0_in;
         text1_ff      <= text1_in;
         len1_ff       <= len1_in;
         pos0_ff       <= pos0_in;
         pos1_ff       <= pos1_in;
         seen0_ff      <= seen0_in;
         seen1_ff      <= seen1_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.hit_first   = out_ff.hit_first;
   assign rsp_port.hit_second  = out_ff.hit_second;
   assign rsp_port.seen_first  = out_ff.seen_first;
   assign rsp_port.seen_second = out_ff.seen_second;

endmodule

// File: bench/mksm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mksm_tb_pkg
// Scoreboard for the two-keyword stream matcher bench: it tracks both keyword
// match positions and seen flags, predicts one result per byte transfer and
// checks the results that come back in order.
// ----------------------------------------------------------------------------
package mksm_tb_pkg;

   import mksm_pkg::*;

   class keyword_match_tracker;
      text_type    texts [2];
      length_type  lens [2];
      pos_type     progress [2];
      logic        found [2];
      result_type  expected_results [$];
      int unsigned bytes_noted;
      int unsigned results_checked;
      int unsigned hits_first;
      int unsigned hits_second;
      int unsigned errors;

      function new();
         texts[0]        = KeywordText0Reset;
         lens[0]         = KeywordLength0Reset;
         texts[1]        = KeywordText1Reset;
         lens[1]         = KeywordLength1Reset;
         progress[0]     = '0;
         progress[1]     = '0;
         found[0]        = 1'b0;
         found[1]        = 1'b0;
         bytes_noted     = 0;
         results_checked = 0;
         hits_first      = 0;
         hits_second     = 0;
         errors          = 0;
      endfunction

      // zero acts as one, anything past the maximum saturates
      function int unsigned span(length_type len);
         if (len == '0) begin
            return 1;
         end
         if (len > MaxKeywordChars) begin
            return MaxKeywordChars;
         end
         return 32'(len);
      endfunction

      function void set_reg(csr_reg_type idx, text_type data);
         case (idx)
            CSR_KEYWORD_TEXT_0:   texts[0] = data;
            CSR_KEYWORD_LENGTH_0: lens[0]  = length_type'(data);
            CSR_KEYWORD_TEXT_1:   texts[1] = data;
            CSR_KEYWORD_LENGTH_1: lens[1]  = length_type'(data);
            default: ;
         endcase
      endfunction

      function logic advance_keyword(int unsigned k, char_type b);
         int unsigned limit;
         int unsigned cursor;
         int unsigned reach;
         limit  = span(lens[k]);
         cursor = 32'(progress[k]);
         // a stale position past the length still compares its own character
         if (texts[k][8*cursor +: 8] == b) begin
            reach = cursor + 1;
         end else if (texts[k][7:0] == b) begin
            reach = 1;
         end else begin
            reach = 0;
         end
         if (reach >= limit) begin
            progress[k] = '0;
            found[k]    = 1'b1;
            return 1'b1;
         end
         progress[k] = pos_type'(reach);
         return 1'b0;
      endfunction

      function void note_byte(char_type b);
         result_type r;
         r.hit_first   = advance_keyword(0, b);
         r.hit_second  = advance_keyword(1, b);
         r.seen_first  = found[0];
         r.seen_second = found[1];
         expected_results.push_back(r);
         bytes_noted++;
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $error("result with no byte waiting: hit_first=%0b hit_second=%0b",
                   got.hit_first, got.hit_second);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (want.hit_first) hits_first++;
         if (want.hit_second) hits_second++;
         if (got.hit_first !== want.hit_first) begin
            $error("hit_first: expected %0b, actual %0b", want.hit_first, got.hit_first);
            errors++;
         end
         if (got.hit_second !== want.hit_second) begin
            $error("hit_second: expected %0b, actual %0b", want.hit_second, got.hit_second);
            errors++;
         end
         if (got.seen_first !== want.seen_first) begin
            $error("seen_first: expected %0b, actual %0b", want.seen_first, got.seen_first);
            errors++;
         end
         if (got.seen_second !== want.seen_second) begin
            $error("seen_second: expected %0b, actual %0b", want.seen_second,
                   got.seen_second);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the two-keyword stream matcher: directed byte strings for the
// default keywords, restarts, stale positions and length extremes, then
// phases of random keyword settings fed with keyword-heavy random streams
// under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;

   import mksm_pkg::*;
   import mksm_tb_pkg::*;

   localparam int unsigned ItemTarget    = 1550;
   localparam int unsigned HoldCycles    = 60;
   localparam int unsigned WatchdogLimit = 2000;

   logic     clock;
   logic     reset;
   logic     csr_write_enable;
   csr_index_type csr_index;
   text_type csr_write_data;

   mksm_req_if req_bus ();
   mksm_rsp_if rsp_bus ();

   multi_keyword_stream_matcher_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   keyword_match_tracker tracker = new();

   int unsigned burst_left    = 0;
   bit          steady_phase  = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_started = 0;
   int unsigned hold_left     = 0;
   int unsigned stall_cycle   = 0;
   int unsigned idle_cycles   = 0;
   int unsigned settings      = 0;
   char_type    letters [4];
   int unsigned letter_count  = 1;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_byte(char_type b);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_byte(b);
   endtask

   // bursts of random length with random gaps, unless the phase runs steady
   task automatic push_byte(char_type b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = steady_phase ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_byte(b);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(char_type'(s[i]));
      end
   endtask

   task automatic push_keyword(int unsigned k, int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         push_byte(tracker.texts[k][8*i +: 8]);
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, text_type data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   task automatic load_keywords(text_type t0, length_type l0, text_type t1, length_type l1);
      write_csr(CSR_KEYWORD_TEXT_0, t0);
      write_csr(CSR_KEYWORD_LENGTH_0, text_type'(l0));
      write_csr(CSR_KEYWORD_TEXT_1, t1);
      write_csr(CSR_KEYWORD_LENGTH_1, text_type'(l1));
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   // result checking and the receiver's own stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_result('{rsp_bus.hit_first, rsp_bus.hit_second,
                                rsp_bus.seen_first, rsp_bus.seen_second});
      end
      stall_cycle++;
      if (holds_started != hold_requests) begin
         holds_started = hold_requests;
         hold_left     = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case ((stall_cycle / 64) % 4)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= logic'($urandom_range(0, 1));
            2: rsp_bus.ready <= (stall_cycle % 4 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("no transfer for %0d cycles", WatchdogLimit);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      text_type    fresh_text [2];
      length_type  fresh_len [2];
      int unsigned phase;
      int unsigned count;
      int unsigned k;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_KEYWORD_TEXT_0;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.rx_byte  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default keywords, a restart on the first character, byte extremes
      push_text("LLinux");
      push_text("Arc");
      push_byte(8'h00);
      push_byte(8'hFF);
      // shorten the first keyword while its position sits at 4
      push_text("Linu");
      wait_for_results();
      load_keywords(tracker.texts[0], 4'd2, tracker.texts[1], tracker.lens[1]);
      push_byte("x");
      wait_for_results();
      // length zero acts as one, length fifteen saturates to eight
      load_keywords('0, 4'd0, '1, 4'd15);
      push_byte(8'h00);
      repeat (8) push_byte(8'hFF);
      wait_for_results();

      phase = 0;
      while (tracker.bytes_noted < ItemTarget) begin
         letter_count = $urandom_range(1, 4);
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
               0: letters[i] = 8'h00;
               1: letters[i] = 8'hFF;
               default: letters[i] = char_type'($urandom_range(0, 255));
            endcase
         end
         for (int j = 0; j < 2; j++) begin
            if ($urandom_range(0, 5) == 0) begin
               fresh_text[j] = {$urandom, $urandom};
            end else begin
               for (int i = 0; i < 8; i++) begin
                  fresh_text[j][8*i +: 8] = letters[$urandom_range(0, letter_count - 1)];
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               fresh_len[j] = length_type'($urandom_range(0, 15));
            end else begin
               fresh_len[j] = length_type'($urandom_range(1, 8));
            end
         end
         if (phase == 0) begin
            fresh_len[0] = 4'd8;
            fresh_len[1] = 4'd1;
         end else if (phase == 1) begin
            fresh_len[0] = 4'd0;
            fresh_len[1] = 4'd15;
         end
         load_keywords(fresh_text[0], fresh_len[0], fresh_text[1], fresh_len[1]);
         steady_phase = ($urandom_range(0, 3) == 0);

         // output held off while input keeps coming, so the buffer fills up
         if (phase == 2) begin
            hold_requests++;
            repeat (40) send_byte(letters[$urandom_range(0, letter_count - 1)]);
         end

         count = $urandom_range(20, 80);
         for (int unsigned n = 0; n < count && tracker.bytes_noted < ItemTarget; n++) begin
            k = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: push_keyword(k, tracker.span(tracker.lens[k]));
               4, 5: push_keyword(k, $urandom_range(1, tracker.span(tracker.lens[k])));
               6, 7: push_byte(letters[$urandom_range(0, letter_count - 1)]);
               8: push_byte(char_type'($urandom_range(0, 255)));
               default: push_byte(tracker.texts[k][8*$urandom_range(0, 7) +: 8]);
            endcase
         end
         wait_for_results();
         phase++;
      end

      repeat (4) @(posedge clock);
      $display("covered %0d bytes and %0d results over %0d keyword settings",
               tracker.bytes_noted, tracker.results_checked, settings);
      $display("first keyword completed %0d times, second keyword %0d times",
               tracker.hits_first, tracker.hits_second);
      if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
